@@ sv/inw_pkg.sv @@
// shared types, constants and helper functions for the indian number speller
// no dependencies; imported by every module of the block
package inw_pkg;

    // input value and binary to decimal conversion
    localparam int VALUE_W       = 30;
    localparam int DIGITS        = 9;
    localparam int DIGIT_W       = 4;
    localparam int BCD_W         = DIGITS * DIGIT_W;
    localparam int BITS_PER_STEP = 3;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(STEPS + 1);

    localparam logic [VALUE_W-1:0] VALUE_MAX = 30'd999999999;

    // queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // token codes
    localparam int CODE_W = 5;
    typedef logic [CODE_W-1:0] t_code;

    localparam t_code CODE_ONE       = 5'd0;
    localparam t_code CODE_TENS_BASE = 5'd17;
    localparam t_code CODE_CRORE     = 5'd27;
    localparam t_code CODE_LAKH      = 5'd28;
    localparam t_code CODE_THOUSAND  = 5'd29;
    localparam t_code CODE_HUNDRED   = 5'd30;
    localparam t_code CODE_AND       = 5'd31;

    // token slots in spoken order
    localparam int NUM_SLOTS = 14;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam int SLOT_CRORE_A    = 0;
    localparam int SLOT_CRORE_B    = 1;
    localparam int SLOT_CRORE_S    = 2;
    localparam int SLOT_LAKH_A     = 3;
    localparam int SLOT_LAKH_B     = 4;
    localparam int SLOT_LAKH_S     = 5;
    localparam int SLOT_THOUSAND_A = 6;
    localparam int SLOT_THOUSAND_B = 7;
    localparam int SLOT_THOUSAND_S = 8;
    localparam int SLOT_HUNDRED_A  = 9;
    localparam int SLOT_HUNDRED_S  = 10;
    localparam int SLOT_AND        = 11;
    localparam int SLOT_LAST_A     = 12;
    localparam int SLOT_LAST_B     = 13;

    // one converted item moving from front to back
    typedef struct packed {
        logic             err;
        logic [BCD_W-1:0] bcd;
    } t_job;

    // tokens of one two-digit group
    typedef struct packed {
        logic  nz;
        logic  a_en;
        t_code a_code;
        logic  b_en;
        t_code b_code;
    } t_grp;

    // one double-dabble step: adjust every digit, then shift one bit in
    function automatic logic [BCD_W-1:0] bcd_shift_in(input logic [BCD_W-1:0] bcd,
                                                      input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (adj[DIGIT_W*d +: DIGIT_W] >= 4'd5) begin
                adj[DIGIT_W*d +: DIGIT_W] = adj[DIGIT_W*d +: DIGIT_W] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // word tokens of a group given its tens and units digits
    function automatic t_grp plan_group(input logic [DIGIT_W-1:0] t,
                                        input logic [DIGIT_W-1:0] u);
        t_grp g;
        logic big;
        big      = (t >= 4'd2);
        g.nz     = (t != '0) || (u != '0);
        g.a_en   = g.nz;
        g.a_code = big ? (t_code'(t) + CODE_TENS_BASE)
                       : (t_code'(u) + (t[0] ? 5'd10 : 5'd0) - 5'd1);
        g.b_en   = big && (u != '0);
        g.b_code = t_code'(u) - 5'd1;
        return g;
    endfunction

endpackage

@@ sv/inw_front.sv @@
// front part: accepts a value, flags range errors, converts it to decimal digits
// depends on inw_pkg
module inw_front import inw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output t_job               o_push_job
);

    logic                  r_busy, n_busy;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_W-1:0]    r_shift, n_shift;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_err, n_err;
    logic                  done;
    logic                  accept;
    logic [BCD_W-1:0]      step_bcd;

    // conversion finished, waiting for the queue
    assign done         = r_busy && (r_cnt == STEP_CNT_W'(STEPS));
    assign o_ready      = !r_busy || (done && i_push_ready);
    assign accept       = i_valid && o_ready;
    assign o_push_valid = done;
    assign o_push_job   = '{err: r_err, bcd: r_bcd};

    // several dabble steps per cycle
    always_comb begin
        step_bcd = r_bcd;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            step_bcd = bcd_shift_in(step_bcd, r_shift[VALUE_W-1-k]);
        end
    end

    // next state of the converter
    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_err   = r_err;
        if (done && i_push_ready) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_shift = i_value;
            n_bcd   = '0;
            n_err   = (i_value == '0) || (i_value > VALUE_MAX);
        end else if (r_busy && !done) begin
            n_bcd   = step_bcd;
            n_shift = r_shift << BITS_PER_STEP;
            n_cnt   = r_cnt + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_err   <= n_err;
    end

endmodule

@@ sv/inw_queue.sv @@
// short first-in first-out queue of converted items between front and back
// depends on inw_pkg
module inw_queue import inw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

@@ sv/inw_back.sv @@
// back part: plans the token slots of one item and sends one token per transfer
// depends on inw_pkg
module inw_back import inw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_pop_valid,
    output logic  o_pop_ready,
    input  t_job  i_pop_job,
    output logic  o_valid,
    input  logic  i_ready,
    output t_code o_word_code,
    output logic  o_last_word,
    output logic  o_range_error
);

    logic [NUM_SLOTS-1:0]             r_mask, n_mask;
    logic [NUM_SLOTS-1:0][CODE_W-1:0] r_codes, n_codes;
    logic                             r_err, n_err;
    logic                             r_o_valid, n_o_valid;
    t_code                            r_o_code, n_o_code;
    logic                             r_o_last, n_o_last;
    logic                             r_o_err, n_o_err;

    logic [NUM_SLOTS-1:0]             plan_mask;
    logic [NUM_SLOTS-1:0][CODE_W-1:0] plan_codes;
    logic [DIGITS-1:0][DIGIT_W-1:0]   dig;
    t_grp                             g_crore, g_lakh, g_thousand, g_last;
    logic                             upper_nz;

    logic [SLOT_W-1:0]    sel;
    logic [NUM_SLOTS-1:0] rest;
    logic                 out_free;
    logic                 emit;
    logic                 load;

    // token plan of the item at the head of the queue
    always_comb begin
        dig        = i_pop_job.bcd;
        g_crore    = plan_group(dig[8], dig[7]);
        g_lakh     = plan_group(dig[6], dig[5]);
        g_thousand = plan_group(dig[4], dig[3]);
        g_last     = plan_group(dig[1], dig[0]);
        upper_nz   = g_crore.nz || g_lakh.nz || g_thousand.nz || (dig[2] != '0);

        plan_mask  = '0;
        plan_codes = '0;

        plan_mask[SLOT_CRORE_A]     = g_crore.a_en;
        plan_codes[SLOT_CRORE_A]    = g_crore.a_code;
        plan_mask[SLOT_CRORE_B]     = g_crore.b_en;
        plan_codes[SLOT_CRORE_B]    = g_crore.b_code;
        plan_mask[SLOT_CRORE_S]     = g_crore.nz;
        plan_codes[SLOT_CRORE_S]    = CODE_CRORE;

        plan_mask[SLOT_LAKH_A]      = g_lakh.a_en;
        plan_codes[SLOT_LAKH_A]     = g_lakh.a_code;
        plan_mask[SLOT_LAKH_B]      = g_lakh.b_en;
        plan_codes[SLOT_LAKH_B]     = g_lakh.b_code;
        plan_mask[SLOT_LAKH_S]      = g_lakh.nz;
        plan_codes[SLOT_LAKH_S]     = CODE_LAKH;

        plan_mask[SLOT_THOUSAND_A]  = g_thousand.a_en;
        plan_codes[SLOT_THOUSAND_A] = g_thousand.a_code;
        plan_mask[SLOT_THOUSAND_B]  = g_thousand.b_en;
        plan_codes[SLOT_THOUSAND_B] = g_thousand.b_code;
        plan_mask[SLOT_THOUSAND_S]  = g_thousand.nz;
        plan_codes[SLOT_THOUSAND_S] = CODE_THOUSAND;

        plan_mask[SLOT_HUNDRED_A]   = (dig[2] != '0);
        plan_codes[SLOT_HUNDRED_A]  = t_code'(dig[2]) - 5'd1;
        plan_mask[SLOT_HUNDRED_S]   = (dig[2] != '0);
        plan_codes[SLOT_HUNDRED_S]  = CODE_HUNDRED;

        // and only joins a non-zero last group to something before it
        plan_mask[SLOT_AND]         = g_last.nz && upper_nz;
        plan_codes[SLOT_AND]        = CODE_AND;

        plan_mask[SLOT_LAST_A]      = g_last.a_en;
        plan_codes[SLOT_LAST_A]     = g_last.a_code;
        plan_mask[SLOT_LAST_B]      = g_last.b_en;
        plan_codes[SLOT_LAST_B]     = g_last.b_code;

        // out of range: a single flagged token
        if (i_pop_job.err) begin
            plan_mask               = '0;
            plan_mask[SLOT_CRORE_A] = 1'b1;
            plan_codes[SLOT_CRORE_A] = CODE_ONE;
        end
    end

    // lowest pending slot goes next
    always_comb begin
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = SLOT_W'(i);
            end
        end
        rest = r_mask & (r_mask - 1'b1);
    end

    assign out_free    = !r_o_valid || i_ready;
    assign emit        = (r_mask != '0) && out_free;
    assign o_pop_ready = (r_mask == '0) || (emit && (rest == '0));
    assign load        = i_pop_valid && o_pop_ready;

    // slot sequencing and output register
    always_comb begin
        n_mask    = r_mask;
        n_codes   = r_codes;
        n_err     = r_err;
        n_o_valid = r_o_valid && !i_ready;
        n_o_code  = r_o_code;
        n_o_last  = r_o_last;
        n_o_err   = r_o_err;
        if (emit) begin
            n_o_valid = 1'b1;
            n_o_code  = r_codes[sel];
            n_o_last  = (rest == '0);
            n_o_err   = r_err;
            n_mask    = rest;
        end
        if (load) begin
            n_mask  = plan_mask;
            n_codes = plan_codes;
            n_err   = i_pop_job.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_mask    <= n_mask;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_codes  <= n_codes;
        r_err    <= n_err;
        r_o_code <= n_o_code;
        r_o_last <= n_o_last;
        r_o_err  <= n_o_err;
    end

    assign o_valid       = r_o_valid;
    assign o_word_code   = r_o_code;
    assign o_last_word   = r_o_last;
    assign o_range_error = r_o_err;

endmodule

@@ sv/indian_number_to_word_tokens_core.sv @@
// Indian-system number speller: one binary value in, a stream of word tokens out.
// Input channel i_valid/o_ready carries i_value; output channel o_valid/i_ready
// carries o_word_code, o_last_word (final token of the value) and o_range_error.
// A value of zero or above 999999999 gives one token with o_range_error set.
// The front converts the value to nine decimal digits, three bits a cycle:
// a value is taken, then the conversion steps run; while busy, the input takes a
// new value only in the same cycle that the finished one moves on to the queue.
// A two-entry queue sits between the front and the back part.
// The back sends one token per cycle from its output register while the
// receiver takes them; an item has 1 to 14 tokens, with no gap between items.
// The front converts a new value while the back still sends earlier tokens.
// With the queue and back empty, a value goes through the conversion, the queue
// entry, the back's slot registers and its output register to its first token.
// Reset (synchronous, active low) empties the converter, queue and output.
// When the receiver stalls the output register holds its token, the back
// stops, the queue fills and then o_ready stays low until room appears.
// depends on inw_pkg, inw_front, inw_queue, inw_back
module indian_number_to_word_tokens_core import inw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CODE_W-1:0]  o_word_code,
    output logic               o_last_word,
    output logic               o_range_error
);

    logic w_push_valid;
    logic w_push_ready;
    t_job w_push_job;
    logic w_pop_valid;
    logic w_pop_ready;
    t_job w_pop_job;

    // accept, range check and decimal conversion
    inw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    // decoupling queue
    inw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    // token planning and output
    inw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (w_pop_valid),
        .o_pop_ready   (w_pop_ready),
        .i_pop_job     (w_pop_job),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_word_code   (o_word_code),
        .o_last_word   (o_last_word),
        .o_range_error (o_range_error)
    );

    // a range error is a single token with the first code
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_last_word && (o_word_code == CODE_ONE))
        else $error("range error token is not a lone first-code token");

    // and never ends a value
    a_and_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_word |-> (o_word_code != CODE_AND))
        else $error("and token marked as last word");

    // the converter is busy in the cycle after a transfer in
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("front ready straight after taking a value");

    // a converted item is held by the front while the queue is full
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid && !w_push_ready |=> w_push_valid && $stable(w_push_job))
        else $error("converted item lost while queue full");

endmodule
